>>> rtl/lrae_pkg.sv
// Shared types, character codes and operator decoding for the arithmetic evaluator.
`default_nettype none

package lrae_pkg;

  localparam int unsigned RESULT_W        = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 64;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_EQUAL = 8'd61;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_EQ   = 3'd5
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input character is taken this cycle
    logic step;    // one multiply or divide iteration
    logic finish;  // write the iterated result back
    logic emit;    // load the output register and clear the line state
  } lrae_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic long_op;    // the character on the input needs an iterated operation
    logic iter_last;  // the current iteration is the final one
    logic out_free;   // the output register can take a new result
  } lrae_sts_t;

  function automatic op_e op_code(input logic [7:0] ch);
    op_e op;
    unique case (ch)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_EQUAL: op = OP_EQ;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lrae_ctrl.sv
// Controller state machine of the arithmetic evaluator.
`default_nettype none

module lrae_ctrl
  import lrae_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_last_i,
  output logic           in_ready_o,
  input  wire lrae_sts_t sts_i,
  output lrae_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       last_q, last_d;

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          last_d = in_last_i;
          if (sts_i.long_op) begin
            state_d = S_RUN;
          end else if (in_last_i) begin
            state_d = S_EMIT;
          end
        end
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        if (sts_i.iter_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = last_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.step, cmd_o.finish, cmd_o.emit}))
    else $error("more than one datapath command at once");

  a_run_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && sts_i.iter_last) |=> state_q == S_FIN)
    else $error("iteration end did not lead to write-back");

  a_fin_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && last_q) |=> state_q == S_EMIT)
    else $error("line end after an iterated operation produced no result");
`endif

endmodule

`default_nettype wire

>>> rtl/lrae_dp.sv
// Datapath of the arithmetic evaluator: line state, shift-add multiplier and divider.
`default_nettype none

module lrae_dp
  import lrae_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          ch_i,
  input  wire lrae_cmd_t           cmd_i,
  output lrae_sts_t                sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [RESULT_W-1:0]      out_result_o,
  output logic                     out_dz_o
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] x);
    return x[W-1] ? (W'(0) - x) : x;
  endfunction

  logic [W-1:0]    acc_q, opnd_q;
  op_e             pend_q, nxt_op_q;
  logic            err_q;
  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic [RESULT_W-1:0] out_res_q;
  logic            out_dz_q;

  logic            is_digit;
  op_e             op;
  logic [W-1:0]    digit;
  logic [W-1:0]    dec_next;
  logic            start;
  logic [W:0]      shl;
  logic [W:0]      trial;

  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign op       = op_code(ch_i);
  assign digit    = W'(ch_i[3:0]);
  // x * 10 + d as two shifted copies and the digit.
  assign dec_next = ((pend_q == OP_NONE) ? ((acc_q << 3) + (acc_q << 1))
                                         : ((opnd_q << 3) + (opnd_q << 1))) + digit;
  assign start    = !is_digit && (op != OP_NONE) &&
                    (pend_q == OP_MUL || pend_q == OP_DIV);

  // Restoring division: shift in the next dividend bit, try to subtract.
  assign shl   = {rem_q, quo_q[W-1]};
  assign trial = shl - {1'b0, dvs_q};

  assign sts_o.long_op   = start;
  assign sts_o.iter_last = (cnt_q == CntW'(W - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Line state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      opnd_q <= '0;
      pend_q <= OP_NONE;
      err_q  <= 1'b0;
    end else if (cmd_i.emit) begin
      acc_q  <= '0;
      opnd_q <= '0;
      pend_q <= OP_NONE;
      err_q  <= 1'b0;
    end else if (cmd_i.finish) begin
      pend_q <= nxt_op_q;
      opnd_q <= '0;
      if (pend_q == OP_MUL) begin
        acc_q <= rem_q;
      end else if (opnd_q == '0) begin
        acc_q <= '0;
        err_q <= 1'b1;
      end else begin
        acc_q <= neg_q ? (W'(0) - quo_q) : quo_q;
      end
    end else if (cmd_i.accept) begin
      if (is_digit) begin
        if (pend_q == OP_NONE) begin
          acc_q <= dec_next;
        end else begin
          opnd_q <= dec_next;
        end
      end else if (op != OP_NONE && !start) begin
        pend_q <= op;
        opnd_q <= '0;
        case (pend_q)
          OP_ADD:  acc_q <= acc_q + opnd_q;
          OP_SUB:  acc_q <= acc_q - opnd_q;
          default: acc_q <= acc_q;
        endcase
      end
    end
  end

  // Iteration registers, shared by multiply (product, multiplier, multiplicand)
  // and divide (remainder, quotient, divisor).
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && start) begin
      rem_q    <= '0;
      cnt_q    <= '0;
      nxt_op_q <= op;
      neg_q    <= acc_q[W-1] ^ opnd_q[W-1];
      if (pend_q == OP_MUL) begin
        quo_q <= opnd_q;
        dvs_q <= acc_q;
      end else begin
        quo_q <= mag_f(acc_q);
        dvs_q <= mag_f(opnd_q);
      end
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CntW'(1);
      if (pend_q == OP_MUL) begin
        if (quo_q[0]) begin
          rem_q <= rem_q + dvs_q;
        end
        quo_q <= quo_q >> 1;
        dvs_q <= dvs_q << 1;
      end else if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shl[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_res_q <= RESULT_W'($signed(acc_q));
      out_dz_q  <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_res_q;
  assign out_dz_o     = out_dz_q;

endmodule

`default_nettype wire

>>> rtl/left_to_right_arith_evaluator.sv
// Top level of the left-to-right arithmetic line evaluator.
`default_nettype none

// The block reads an arithmetic line one ASCII character per transfer and
// evaluates it strictly left to right, without operator precedence. Digits
// build the current operand; each of + - * / = applies the operator before it
// to the accumulator and the operand, then becomes the pending operator. The
// first operator of a line only becomes pending. Other characters are ignored,
// and an operand without digits counts as zero. Digits after the last operator
// are never applied. A transfer with tlast set ends the line: after that
// character is handled, one result transfer carries the accumulator as a
// signed 64-bit value, sign-extended from VALUE_WIDTH bits, and tuser flags any
// division by zero on the line (such a division gives zero). Arithmetic wraps
// at VALUE_WIDTH bits; division truncates toward zero. A digit, an ignored
// character or an operator that applies nothing, +, - or =, is handled as it
// is taken. An operator whose pending operator is * or / runs through a shared
// shift-add multiplier / restoring divider one bit per cycle, and no further
// character is taken until its result is written back. At the end of a line
// the output register is loaded; it holds the result while the next line's
// characters are already taken, and only a second line end waits for the
// register to empty.
module left_to_right_arith_evaluator
  import lrae_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,   // [7:0] ch
  input  wire logic                s_axis_tlast_i,   // line_end
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [RESULT_W-1:0]      m_axis_tdata_o,   // [63:0] result
  output logic [0:0]               m_axis_tuser_o    // [0] div_by_zero
);

  lrae_cmd_t cmd;
  lrae_sts_t sts;
  logic      dz;

  lrae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrae_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ch_i         (s_axis_tdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_o (m_axis_tdata_o),
    .out_dz_o     (dz)
  );

  assign m_axis_tuser_o = dz;

endmodule

`default_nettype wire
